@@ hw/rtl/button_joystick_debounce_repeat_assert.svh @@
// assertion macros for the debounce and autorepeat block
`ifndef BUTTON_JOYSTICK_DEBOUNCE_REPEAT_ASSERT_SVH
`define BUTTON_JOYSTICK_DEBOUNCE_REPEAT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define BJDR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bjdr assertion failed");

// next-cycle implication, clocked on clk_i, off while in reset
`define BJDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bjdr assertion failed");

`endif

@@ hw/rtl/bjdr_pkg.sv @@
// shared types and constants of the debounce and autorepeat block
`default_nettype none

package bjdr_pkg;

  localparam int unsigned ButtonBits = 5;
  localparam int unsigned VecBits    = 9;
  localparam int unsigned BitRight   = 5;
  localparam int unsigned BitLeft    = 6;
  localparam int unsigned BitUp      = 7;
  localparam int unsigned BitDown    = 8;
  localparam int unsigned AxisW      = 12;
  localparam int unsigned StepW      = 8;
  localparam int unsigned CountW     = 16;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepUp      = 3'd0,
    CfgStepDown    = 3'd1,
    CfgUpperPress  = 3'd2,
    CfgUpperRel    = 3'd3,
    CfgLowerPress  = 3'd4,
    CfgLowerRel    = 3'd5,
    CfgRptDelay    = 3'd6,
    CfgRptPeriod   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [StepW-1:0]  step_up;
    logic [StepW-1:0]  step_down;
    logic [AxisW-1:0]  upper_press;
    logic [AxisW-1:0]  upper_rel;
    logic [AxisW-1:0]  lower_press;
    logic [AxisW-1:0]  lower_rel;
    logic [CountW-1:0] rpt_delay;
    logic [CountW-1:0] rpt_period;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/bjdr_btn_lane.sv @@
// one button lane: saturating integrator and debounced bit
`default_nettype none

module bjdr_btn_lane #(
  parameter int unsigned PRESSED_LEVEL = 255
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           raw_i,
  input  wire bjdr_pkg::cfg_t cfg_i,
  output logic                db_q_o,
  output logic                db_d_o
);

  localparam logic [bjdr_pkg::StepW:0] FullLevel = (bjdr_pkg::StepW+1)'(PRESSED_LEVEL);

  logic [bjdr_pkg::StepW-1:0] lvl_q, lvl_d;
  logic                       db_q, db_d;
  logic [bjdr_pkg::StepW:0]   sum;

  always_comb begin
    sum   = {1'b0, lvl_q} + {1'b0, cfg_i.step_up};
    lvl_d = lvl_q;
    db_d  = db_q;
    if (raw_i) begin
      if (sum >= FullLevel) begin
        lvl_d = FullLevel[bjdr_pkg::StepW-1:0];
        db_d  = 1'b1;
      end else begin
        lvl_d = sum[bjdr_pkg::StepW-1:0];
      end
    end else if (lvl_q <= cfg_i.step_down) begin
      lvl_d = '0;
      db_d  = 1'b0;
    end else begin
      lvl_d = lvl_q - cfg_i.step_down;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
      db_q  <= 1'b0;
    end else if (en_i) begin
      lvl_q <= lvl_d;
      db_q  <= db_d;
    end
  end

  assign db_q_o = db_q;
  assign db_d_o = db_d;

endmodule

`default_nettype wire

@@ hw/rtl/bjdr_axis.sv @@
// one joystick axis: hysteresis for the high and low direction bits
`default_nettype none

module bjdr_axis (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic [bjdr_pkg::AxisW-1:0] sample_i,
  input  wire bjdr_pkg::cfg_t             cfg_i,
  output logic [1:0]                      dir_q_o,
  output logic [1:0]                      dir_d_o
);

  // bit 0 high direction (right or up), bit 1 low direction (left or down)
  logic [1:0] dir_q, dir_d;

  always_comb begin
    dir_d = dir_q;
    if (sample_i > cfg_i.upper_press) dir_d[0] = 1'b1;
    if (sample_i < cfg_i.upper_rel)   dir_d[0] = 1'b0;
    if (sample_i < cfg_i.lower_press) dir_d[1] = 1'b1;
    if (sample_i > cfg_i.lower_rel)   dir_d[1] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= '0;
    end else if (en_i) begin
      dir_q <= dir_d;
    end
  end

  assign dir_q_o = dir_q;
  assign dir_d_o = dir_d;

endmodule

`default_nettype wire

@@ hw/rtl/bjdr_rpt_lane.sv @@
// one autorepeat lane: hold counter and repeat phase counter
`default_nettype none

module bjdr_rpt_lane (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           level_i,
  input  wire bjdr_pkg::cfg_t cfg_i,
  output logic                fire_o
);

  logic [bjdr_pkg::CountW-1:0] held_q, held_d, held_inc;
  logic [bjdr_pkg::CountW-1:0] phase_q, phase_d;
  logic [bjdr_pkg::CountW:0]   phase_inc;
  logic                        fire;

  always_comb begin
    held_inc  = held_q + 1'b1;
    phase_inc = {1'b0, phase_q} + 1'b1;
    held_d    = held_q;
    phase_d   = phase_q;
    fire      = 1'b0;
    if (!level_i) begin
      held_d  = '0;
      phase_d = '0;
    end else if (held_q < cfg_i.rpt_delay) begin
      held_d = held_inc;
      if (held_inc == cfg_i.rpt_delay) begin
        fire    = 1'b1;
        phase_d = '0;
      end
    end else if (phase_inc >= {1'b0, cfg_i.rpt_period}) begin
      fire    = 1'b1;
      phase_d = '0;
    end else begin
      phase_d = phase_inc[bjdr_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      phase_q <= '0;
    end else if (en_i) begin
      held_q  <= held_d;
      phase_q <= phase_d;
    end
  end

  assign fire_o = fire;

endmodule

`default_nettype wire

@@ hw/rtl/bjdr_merge.sv @@
// merge of lane results into presses, with a two-entry output buffer
`default_nettype none

module bjdr_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic [bjdr_pkg::VecBits-1:0]  old_vec_i,
  input  wire logic [bjdr_pkg::VecBits-1:0]  new_vec_i,
  input  wire logic [bjdr_pkg::VecBits-1:0]  repeats_i,
  output logic                               ready_o,
  output logic                               m_valid_o,
  input  wire logic                          m_ready_i,
  output logic [bjdr_pkg::OutDataW-1:0]      m_data_o
);

  localparam int unsigned PadW = bjdr_pkg::OutDataW - 2 * bjdr_pkg::VecBits;

  logic [bjdr_pkg::OutDataW-1:0] res;
  logic [bjdr_pkg::OutDataW-1:0] out_q, skid_q;
  logic                          out_vld_q, skid_vld_q;
  logic                          pop;
  logic [bjdr_pkg::VecBits-1:0]  presses;

  assign presses = (~old_vec_i & new_vec_i) | repeats_i;
  assign res     = {{PadW{1'b0}}, new_vec_i, presses};
  assign pop     = out_vld_q && m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push_i;
      end
    end else if (push_i) begin
      if (out_vld_q) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= res;
      end
    end else if (push_i) begin
      if (out_vld_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign ready_o   = !skid_vld_q;
  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/button_joystick_debounce_repeat.sv @@
// top level of the button and joystick debouncer with autorepeat
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   raw_buttons, joystick_x, joystick_y
// m_axis    out  m_axis_tvalid/m_axis_tready   presses, debounced
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// one scan tick per cycle while s_axis_tready is high; the result is registered in the output buffer
// all lanes update in the accepting cycle, set by the integrator and counter adds
// two-entry output buffer: s_axis_tready drops only when both entries are full
// reset clears integrators, debounced bits and counters and loads register defaults
// configuration writes are taken every cycle
`default_nettype none

module button_joystick_debounce_repeat #(
  parameter int unsigned PRESSED_LEVEL = 255,
  parameter int unsigned BUTTON_LANES  = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // raw_buttons[4:0], joystick_x[16:5], joystick_y[28:17], zero pad
  input  wire logic [bjdr_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // presses[8:0], debounced[17:9], zero pad
  output logic [bjdr_pkg::OutDataW-1:0]      m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bjdr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bjdr_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ActiveLanes =
    (BUTTON_LANES < bjdr_pkg::ButtonBits) ? BUTTON_LANES : bjdr_pkg::ButtonBits;

  bjdr_pkg::cfg_t                 cfg_q;
  logic                           accept;
  logic [bjdr_pkg::VecBits-1:0]   old_vec, new_vec, repeats;
  logic [1:0]                     x_q, x_d, y_q, y_d;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_up     <= 8'd1;
      cfg_q.step_down   <= 8'd1;
      cfg_q.upper_press <= 12'd3000;
      cfg_q.upper_rel   <= 12'd2500;
      cfg_q.lower_press <= 12'd1000;
      cfg_q.lower_rel   <= 12'd1500;
      cfg_q.rpt_delay   <= 16'd30;
      cfg_q.rpt_period  <= 16'd3;
    end else if (cfg_valid_i) begin
      unique case (bjdr_pkg::cfg_idx_e'(cfg_index_i))
        bjdr_pkg::CfgStepUp:     cfg_q.step_up     <= cfg_data_i[7:0];
        bjdr_pkg::CfgStepDown:   cfg_q.step_down   <= cfg_data_i[7:0];
        bjdr_pkg::CfgUpperPress: cfg_q.upper_press <= cfg_data_i[11:0];
        bjdr_pkg::CfgUpperRel:   cfg_q.upper_rel   <= cfg_data_i[11:0];
        bjdr_pkg::CfgLowerPress: cfg_q.lower_press <= cfg_data_i[11:0];
        bjdr_pkg::CfgLowerRel:   cfg_q.lower_rel   <= cfg_data_i[11:0];
        bjdr_pkg::CfgRptDelay:   cfg_q.rpt_delay   <= cfg_data_i;
        bjdr_pkg::CfgRptPeriod:  cfg_q.rpt_period  <= cfg_data_i;
      endcase
    end
  end

  for (genvar i = 0; i < bjdr_pkg::ButtonBits; i++) begin : g_btn
    if (i < ActiveLanes) begin : g_on
      bjdr_btn_lane #(
        .PRESSED_LEVEL(PRESSED_LEVEL)
      ) u_lane (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (accept),
        .raw_i (s_axis_tdata[i]),
        .cfg_i (cfg_q),
        .db_q_o(old_vec[i]),
        .db_d_o(new_vec[i])
      );
    end else begin : g_off
      assign old_vec[i] = 1'b0;
      assign new_vec[i] = 1'b0;
    end
  end

  bjdr_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .sample_i(s_axis_tdata[16:5]),
    .cfg_i   (cfg_q),
    .dir_q_o (x_q),
    .dir_d_o (x_d)
  );

  bjdr_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .sample_i(s_axis_tdata[28:17]),
    .cfg_i   (cfg_q),
    .dir_q_o (y_q),
    .dir_d_o (y_d)
  );

  assign old_vec[bjdr_pkg::BitRight] = x_q[0];
  assign old_vec[bjdr_pkg::BitLeft]  = x_q[1];
  assign old_vec[bjdr_pkg::BitUp]    = y_q[0];
  assign old_vec[bjdr_pkg::BitDown]  = y_q[1];
  assign new_vec[bjdr_pkg::BitRight] = x_d[0];
  assign new_vec[bjdr_pkg::BitLeft]  = x_d[1];
  assign new_vec[bjdr_pkg::BitUp]    = y_d[0];
  assign new_vec[bjdr_pkg::BitDown]  = y_d[1];

  for (genvar i = 0; i < bjdr_pkg::VecBits; i++) begin : g_rpt
    bjdr_rpt_lane u_rpt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .level_i(new_vec[i]),
      .cfg_i  (cfg_q),
      .fire_o (repeats[i])
    );
  end

  bjdr_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .old_vec_i(old_vec),
    .new_vec_i(new_vec),
    .repeats_i(repeats),
    .ready_o  (s_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bjdr_checker.sv @@
// port-level checker for the debounce and autorepeat block, with its bind
`default_nettype none

`include "button_joystick_debounce_repeat_assert.svh"

module bjdr_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [bjdr_pkg::OutDataW-1:0] m_axis_tdata
);

  // a press only on a bit that is debounced high
  `BJDR_ASSERT_NOW(a_press_held, m_axis_tvalid, (m_axis_tdata[8:0] & ~m_axis_tdata[17:9]) == 9'd0)

  `BJDR_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:18] == 6'd0)

  // input backpressure only with a result waiting
  `BJDR_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid)

  `BJDR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind button_joystick_debounce_repeat bjdr_checker u_bjdr_checker (.*);

`default_nettype wire
